// ===== rtl/fac_pkg.sv =====
package fac_pkg;

	localparam int CFG_WIDTH        = 64;
	localparam int CFG_IDX_WIDTH    = 4;
	localparam int NUM_REGS         = 8;
	localparam int REG_IDX_WIDTH    = $clog2(NUM_REGS);
	localparam int HALF_WIDTH       = 32;
	localparam int NUM_PLANES       = 6;
	localparam int NUM_AXES         = 3;
	localparam int NUM_COLS         = 4;
	localparam int W_ROW            = 3;
	localparam int W_COL            = 3;
	localparam int COORD_FRAC       = 8;
	localparam int COORD_WIDTH_DEF  = 24;
	localparam int MATRIX_WIDTH_DEF = 32;

	localparam logic [CFG_WIDTH-1:0] CFG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
	} pipe_ctl_t;

	// register holding matrix entry (col, row)
	function automatic logic [REG_IDX_WIDTH-1:0] reg_sel(input int col, input int row);
		logic [1:0] c2;
		logic [1:0] r2;
		begin
			c2 = col[1:0];
			r2 = row[1:0];
			return {c2, r2[1]};
		end
	endfunction

endpackage

// ===== rtl/fac_cfg.sv =====
module fac_cfg #(
	parameter int MATRIX_WIDTH = fac_pkg::MATRIX_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [fac_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [fac_pkg::CFG_WIDTH-1:0]         cfg_data,
	output logic signed [MATRIX_WIDTH:0]          coef_q [fac_pkg::NUM_PLANES][fac_pkg::NUM_AXES],
	output logic signed [MATRIX_WIDTH:0]          offs_q [fac_pkg::NUM_PLANES]
);
	import fac_pkg::*;

	logic [CFG_WIDTH-1:0]           mat_q [NUM_REGS];
	logic signed [MATRIX_WIDTH-1:0] ent [NUM_COLS][NUM_COLS];
	logic [HALF_WIDTH-1:0]          half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				mat_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_valid && (cfg_index < CFG_IDX_WIDTH'(NUM_REGS))) begin
			mat_q[cfg_index[REG_IDX_WIDTH-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		half = '0;
		for (int c = 0; c < NUM_COLS; c++) begin
			for (int r = 0; r < NUM_COLS; r++) begin
				half = r[0] ? mat_q[reg_sel(c, r)][CFG_WIDTH-1:HALF_WIDTH]
				            : mat_q[reg_sel(c, r)][HALF_WIDTH-1:0];
				ent[c][r] = signed'(half[MATRIX_WIDTH-1:0]);
			end
		end
	end

	// plane p: row p/2 of the matrix added (even p) or subtracted (odd p) from row 3
	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int c = 0; c < NUM_AXES; c++) begin
				if (p[0])
					coef_q[p][c] <= (MATRIX_WIDTH+1)'(ent[c][W_ROW])
					              - (MATRIX_WIDTH+1)'(ent[c][p/2]);
				else
					coef_q[p][c] <= (MATRIX_WIDTH+1)'(ent[c][W_ROW])
					              + (MATRIX_WIDTH+1)'(ent[c][p/2]);
			end
			if (p[0])
				offs_q[p] <= (MATRIX_WIDTH+1)'(ent[W_COL][W_ROW])
				           - (MATRIX_WIDTH+1)'(ent[W_COL][p/2]);
			else
				offs_q[p] <= (MATRIX_WIDTH+1)'(ent[W_COL][W_ROW])
				           + (MATRIX_WIDTH+1)'(ent[W_COL][p/2]);
		end
	end

endmodule

// ===== rtl/fac_plane.sv =====
module fac_plane #(
	parameter int COORD_WIDTH  = fac_pkg::COORD_WIDTH_DEF,
	parameter int MATRIX_WIDTH = fac_pkg::MATRIX_WIDTH_DEF
) (
	input  logic                         clk,
	input  fac_pkg::pipe_ctl_t           ctl,
	input  logic signed [MATRIX_WIDTH:0] coef [fac_pkg::NUM_AXES],
	input  logic signed [MATRIX_WIDTH:0] offs,
	input  logic signed [COORD_WIDTH-1:0] box_min [fac_pkg::NUM_AXES],
	input  logic signed [COORD_WIDTH-1:0] box_max [fac_pkg::NUM_AXES],
	output logic                         neg_s3
);
	import fac_pkg::*;

	localparam int CF_W   = MATRIX_WIDTH + 1;
	localparam int PROD_W = CF_W + COORD_WIDTH;
	localparam int SUM_W  = PROD_W + 2;

	logic signed [COORD_WIDTH-1:0] corner [NUM_AXES];
	logic signed [PROD_W-1:0]      prod_s2 [NUM_AXES];
	logic signed [SUM_W-1:0]       plane_sum;

	// positive-vertex pick: max where the coefficient is above zero
	always_comb begin
		for (int c = 0; c < NUM_AXES; c++) begin
			corner[c] = (!coef[c][CF_W-1] && (|coef[c])) ? box_max[c] : box_min[c];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			for (int c = 0; c < NUM_AXES; c++) begin
				prod_s2[c] <= PROD_W'(coef[c]) * PROD_W'(corner[c]);
			end
		end
	end

	always_comb begin
		plane_sum = SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1]) + SUM_W'(prod_s2[2])
		          + (SUM_W'(offs) <<< COORD_FRAC);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			neg_s3 <= plane_sum[SUM_W-1];
		end
	end

endmodule

// ===== rtl/frustum_aabb_cull_core.sv =====
// Frustum cull core: tests one axis-aligned box per cycle while the output side
// is ready, against the six clip planes of the configured view-projection matrix,
// and returns visible = 0 when some plane has the box's positive vertex strictly
// behind it. The box register loads on the accept edge; corner select and
// multiply, per-plane sum and sign, and the plane AND into the output register
// follow as registered stages in that order. The pipeline takes a new word every
// cycle while the output side is ready, and a stall on the output backs up
// through the stage valids without loss. Matrix writes land on the cycle of the
// handshake and reach the plane coefficients in the cycle after; write only
// while no box is in flight.
module frustum_aabb_cull_core #(
	parameter int COORD_WIDTH  = fac_pkg::COORD_WIDTH_DEF,
	parameter int MATRIX_WIDTH = fac_pkg::MATRIX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fac_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [fac_pkg::CFG_WIDTH-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COORD_WIDTH-1:0]     box_min_x,
	input  logic signed [COORD_WIDTH-1:0]     box_min_y,
	input  logic signed [COORD_WIDTH-1:0]     box_min_z,
	input  logic signed [COORD_WIDTH-1:0]     box_max_x,
	input  logic signed [COORD_WIDTH-1:0]     box_max_y,
	input  logic signed [COORD_WIDTH-1:0]     box_max_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              visible
);
	import fac_pkg::*;

	logic signed [MATRIX_WIDTH:0]    coef_q [NUM_PLANES][NUM_AXES];
	logic signed [MATRIX_WIDTH:0]    offs_q [NUM_PLANES];
	logic signed [COORD_WIDTH-1:0]   bmin_s1 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0]   bmax_s1 [NUM_AXES];
	logic [NUM_PLANES-1:0]           neg_s3;
	logic                            v_s1;
	logic                            v_s2;
	logic                            v_s3;
	logic                            out_valid_q;
	logic                            visible_q;
	logic                            rdy_out;
	logic                            rdy_s3;
	logic                            rdy_s2;
	logic                            rdy_s1;
	pipe_ctl_t                       ctl;

	assign cfg_ready = 1'b1;

	fac_cfg #(
		.MATRIX_WIDTH(MATRIX_WIDTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.coef_q   (coef_q),
		.offs_q   (offs_q)
	);

	assign rdy_out = !out_valid_q || out_ready;
	assign rdy_s3  = !v_s3 || rdy_out;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign ctl.adv_s2 = v_s1 && rdy_s2;
	assign ctl.adv_s3 = v_s2 && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_out) out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			bmin_s1[0] <= box_min_x;
			bmin_s1[1] <= box_min_y;
			bmin_s1[2] <= box_min_z;
			bmax_s1[0] <= box_max_x;
			bmax_s1[1] <= box_max_y;
			bmax_s1[2] <= box_max_z;
		end
		if (v_s3 && rdy_out) begin
			visible_q <= ~|neg_s3;
		end
	end

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		fac_plane #(
			.COORD_WIDTH (COORD_WIDTH),
			.MATRIX_WIDTH(MATRIX_WIDTH)
		) u_plane (
			.clk    (clk),
			.ctl    (ctl),
			.coef   (coef_q[p]),
			.offs   (offs_q[p]),
			.box_min(bmin_s1),
			.box_max(bmax_s1),
			.neg_s3 (neg_s3[p])
		);
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted word did not reach stage 1");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && v_s1 && v_s2 && v_s3 |-> !in_ready)
		else $error("input accepted while pipeline full and stalled");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy_s2 |=> v_s1 && $stable(bmin_s1[0]) && $stable(bmax_s1[2]))
		else $error("stage 1 word lost or changed during stall");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(visible_q))
		else $error("output word changed during stall");

endmodule

// ===== tb/cull_checker.sv =====
`timescale 1ns / 100ps

module cull_checker #(
	parameter int COORD_WIDTH  = fac_pkg::COORD_WIDTH_DEF,
	parameter int MATRIX_WIDTH = fac_pkg::MATRIX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [fac_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [fac_pkg::CFG_WIDTH-1:0]     cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [COORD_WIDTH-1:0]     box_min_x,
	input  logic signed [COORD_WIDTH-1:0]     box_min_y,
	input  logic signed [COORD_WIDTH-1:0]     box_min_z,
	input  logic signed [COORD_WIDTH-1:0]     box_max_x,
	input  logic signed [COORD_WIDTH-1:0]     box_max_y,
	input  logic signed [COORD_WIDTH-1:0]     box_max_z,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              visible,
	output int                                mismatches,
	output int                                open_words
);
	import fac_pkg::*;

	localparam int PRINT_CAP = 40;

	// identity view-projection, packed highest register first
	localparam logic [NUM_REGS-1:0][CFG_WIDTH-1:0] MATRIX_AT_RESET = {
		64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
	};

	logic [NUM_REGS-1:0][CFG_WIDTH-1:0] mat;
	logic visibility_due [$];
	logic want;
	int   words_out;

	initial begin
		mismatches = 0;
		words_out  = 0;
	end

	task automatic report_mismatch(input string what, input logic exp_bit, input logic got_bit);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: cull word %0d: %s want %b got %b",
				$realtime, words_out, what, exp_bit, got_bit);
		mismatches++;
	endtask

	// entry at (col, row): low half holds the even row, sign taken from MATRIX_WIDTH
	function automatic longint matrix_entry(input int col, input int row);
		logic [CFG_WIDTH-1:0]         r;
		logic [HALF_WIDTH-1:0]        h;
		logic signed [HALF_WIDTH-1:0] s;
		r = mat[col * 2 + row / 2];
		h = (row % 2 != 0) ? r[HALF_WIDTH +: HALF_WIDTH] : r[0 +: HALF_WIDTH];
		s = h << (HALF_WIDTH - MATRIX_WIDTH);
		return longint'(s >>> (HALF_WIDTH - MATRIX_WIDTH));
	endfunction

	// positive-vertex test against the six planes row3 +/- row k
	function automatic logic box_in_frustum(
		input logic signed [COORD_WIDTH-1:0] mnx, mny, mnz, mxx, mxy, mxz
	);
		longint lo_c [3];
		longint hi_c [3];
		longint coef;
		longint plane_sum;
		logic   pass;
		lo_c[0] = mnx;
		lo_c[1] = mny;
		lo_c[2] = mnz;
		hi_c[0] = mxx;
		hi_c[1] = mxy;
		hi_c[2] = mxz;
		pass = 1'b1;
		for (int k = 0; k < NUM_AXES; k++) begin
			for (int s = 0; s < 2; s++) begin
				plane_sum = 0;
				for (int c = 0; c < NUM_AXES; c++) begin
					coef = (s == 0) ? matrix_entry(c, W_ROW) + matrix_entry(c, k)
					                : matrix_entry(c, W_ROW) - matrix_entry(c, k);
					plane_sum += coef * ((coef > 0) ? hi_c[c] : lo_c[c]);
				end
				coef = (s == 0) ? matrix_entry(W_COL, W_ROW) + matrix_entry(W_COL, k)
				                : matrix_entry(W_COL, W_ROW) - matrix_entry(W_COL, k);
				plane_sum += coef <<< COORD_FRAC;
				if (plane_sum < 0)
					pass = 1'b0;
			end
		end
		return pass;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat = MATRIX_AT_RESET;
			visibility_due.delete();
			open_words <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
				mat[cfg_index[REG_IDX_WIDTH-1:0]] = cfg_data;
			if (in_valid && in_ready)
				visibility_due.push_back(box_in_frustum(box_min_x, box_min_y, box_min_z,
					box_max_x, box_max_y, box_max_z));
			if (out_valid && out_ready) begin
				words_out++;
				if (visibility_due.size() == 0) begin
					report_mismatch("unexpected word", 1'bx, visible);
				end else begin
					want = visibility_due.pop_front();
					if (visible !== want)
						report_mismatch("visible", want, visible);
				end
			end
			open_words <= visibility_due.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import fac_pkg::*;

	localparam int CW               = COORD_WIDTH_DEF;
	localparam int MW               = MATRIX_WIDTH_DEF;
	localparam int COORD_MIN        = -(1 << (CW - 1));
	localparam int COORD_MAX        = (1 << (CW - 1)) - 1;
	localparam int ONE_COORD        = 1 << COORD_FRAC;
	localparam int ONE_Q16          = 1 << 16;
	localparam int NUM_PHASES       = 10;
	localparam int ITEMS_PER_PHASE  = 134;
	localparam int HOLD_OFF_CYCLES  = 64;
	localparam int DRAIN_CYCLES     = 16;
	localparam int CYCLE_LIMIT      = 400000;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_COL0_ROWS01 = 4'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COL0_ROWS23 = 4'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COL1_ROWS01 = 4'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COL1_ROWS23 = 4'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COL2_ROWS01 = 4'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COL2_ROWS23 = 4'd5;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COL3_ROWS01 = 4'd6;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COL3_ROWS23 = 4'd7;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_FIRST = 4'd8;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_LAST  = 4'd15;

	typedef enum int {
		MAT_PROJECTIVE,
		MAT_IDENTITY,
		MAT_FULL_RANDOM,
		MAT_MOST_NEGATIVE,
		MAT_EXTREME_MIX,
		MAT_MOST_POSITIVE,
		MAT_ALL_ONES,
		MAT_KIND_COUNT
	} mat_kind_e;

	typedef struct packed {
		logic [CW-1:0] min_x;
		logic [CW-1:0] min_y;
		logic [CW-1:0] min_z;
		logic [CW-1:0] max_x;
		logic [CW-1:0] max_y;
		logic [CW-1:0] max_z;
	} box_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0]     cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic signed [CW-1:0]     box_min_x = '0;
	logic signed [CW-1:0]     box_min_y = '0;
	logic signed [CW-1:0]     box_min_z = '0;
	logic signed [CW-1:0]     box_max_x = '0;
	logic signed [CW-1:0]     box_max_y = '0;
	logic signed [CW-1:0]     box_max_z = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     visible;

	int mismatches;
	int open_words;
	int cycle_count     = 0;
	int hold_off_asks   = 0;
	int hold_off_served = 0;
	bit gaps_on         = 1'b0;
	bit stalls_on       = 1'b0;
	int span;

	logic [3:0][3:0][HALF_WIDTH-1:0] mat_q;   // [col][row], Q16.16

	frustum_aabb_cull_core #(
		.COORD_WIDTH (CW),
		.MATRIX_WIDTH(MW)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.box_min_x(box_min_x),
		.box_min_y(box_min_y),
		.box_min_z(box_min_z),
		.box_max_x(box_max_x),
		.box_max_y(box_max_y),
		.box_max_z(box_max_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.visible  (visible)
	);

	cull_checker #(
		.COORD_WIDTH (CW),
		.MATRIX_WIDTH(MW)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.visible   (visible),
		.mismatches(mismatches),
		.open_words(open_words)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stall bursts, plus a long hold-off on request
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_served != hold_off_asks) begin
				hold_off_served = hold_off_asks;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (stalls_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic int rand_signed(input int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic int clamp_coord(input int v);
		return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	function automatic box_t mk(input int mnx, mny, mnz, mxx, mxy, mxz);
		box_t b;
		b.min_x = mnx[CW-1:0];
		b.min_y = mny[CW-1:0];
		b.min_z = mnz[CW-1:0];
		b.max_x = mxx[CW-1:0];
		b.max_y = mxy[CW-1:0];
		b.max_z = mxz[CW-1:0];
		return b;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 6))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2:       return 0;
			3:       return -1;
			4:       return 1;
			5:       return -ONE_COORD;
			default: return ONE_COORD;
		endcase
	endfunction

	function automatic box_t random_box(input int sp);
		int lo [3];
		int hi [3];
		int mid;
		int half;
		int flip;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick >= 7 && pick <= 8)
			return mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		if (pick == 9)
			return mk(extreme_coord(), extreme_coord(), extreme_coord(),
				extreme_coord(), extreme_coord(), extreme_coord());
		for (int a = 0; a < NUM_AXES; a++) begin
			mid   = rand_signed(sp);
			half  = $urandom_range(0, sp / 2);
			lo[a] = clamp_coord(mid - half);
			hi[a] = clamp_coord(mid + half);
		end
		// inverted box: min above max on one axis
		if (pick == 6) begin
			flip     = $urandom_range(0, NUM_AXES - 1);
			mid      = lo[flip];
			lo[flip] = hi[flip] + 1;
			hi[flip] = mid;
		end
		return mk(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
	endfunction

	task automatic fill_matrix(input mat_kind_e kind, input int sp);
		int w;
		w = sp * 256;
		for (int c = 0; c < NUM_COLS; c++) begin
			for (int r = 0; r < NUM_COLS; r++) begin
				case (kind)
					MAT_PROJECTIVE: begin
						if (c == W_COL && r == W_ROW)
							mat_q[c][r] = w + rand_signed(w / 2);
						else if (c == W_COL)
							mat_q[c][r] = rand_signed(w / 2);
						else if (r == W_ROW)
							mat_q[c][r] = rand_signed(ONE_Q16 / 8);
						else if (c == r)
							mat_q[c][r] = ONE_Q16 + rand_signed(ONE_Q16 / 2);
						else
							mat_q[c][r] = rand_signed(ONE_Q16 / 4);
					end
					MAT_IDENTITY:      mat_q[c][r] = (c == r) ? ONE_Q16 : 0;
					MAT_FULL_RANDOM:   mat_q[c][r] = $urandom();
					MAT_MOST_NEGATIVE: mat_q[c][r] = 32'h8000_0000;
					MAT_MOST_POSITIVE: mat_q[c][r] = 32'h7FFF_FFFF;
					MAT_ALL_ONES:      mat_q[c][r] = 32'hFFFF_FFFF;
					default: begin
						case ($urandom_range(0, 4))
							0:       mat_q[c][r] = 32'h8000_0000;
							1:       mat_q[c][r] = 32'h7FFF_FFFF;
							2:       mat_q[c][r] = 32'h0000_0000;
							3:       mat_q[c][r] = 32'hFFFF_FFFF;
							default: mat_q[c][r] = ONE_Q16;
						endcase
					end
				endcase
			end
		end
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_matrix();
		write_reg(REG_COL0_ROWS01, {mat_q[0][1], mat_q[0][0]});
		write_reg(REG_COL0_ROWS23, {mat_q[0][3], mat_q[0][2]});
		write_reg(REG_COL1_ROWS01, {mat_q[1][1], mat_q[1][0]});
		write_reg(REG_COL1_ROWS23, {mat_q[1][3], mat_q[1][2]});
		write_reg(REG_COL2_ROWS01, {mat_q[2][1], mat_q[2][0]});
		write_reg(REG_COL2_ROWS23, {mat_q[2][3], mat_q[2][2]});
		write_reg(REG_COL3_ROWS01, {mat_q[3][1], mat_q[3][0]});
		write_reg(REG_COL3_ROWS23, {mat_q[3][3], mat_q[3][2]});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_box(input box_t b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		box_min_x <= b.min_x;
		box_min_y <= b.min_y;
		box_min_z <= b.min_z;
		box_max_x <= b.max_x;
		box_max_y <= b.max_y;
		box_max_z <= b.max_z;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_words != 0) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset matrix is the identity: visible iff the box touches [-1, 1]^3
		send_box(mk(-ONE_COORD, -ONE_COORD, -ONE_COORD, ONE_COORD, ONE_COORD, ONE_COORD));
		send_box(mk(-1000, -1000, -1000, -ONE_COORD, -ONE_COORD, -ONE_COORD));
		send_box(mk(-1000, -1000, -1000, -ONE_COORD - 1, 0, 0));
		send_box(mk(ONE_COORD, ONE_COORD, ONE_COORD, 1000, 1000, 1000));
		send_box(mk(0, ONE_COORD + 1, 0, 10, 1000, 10));
		send_box(mk(0, 0, -1000, 0, 0, -ONE_COORD - 1));
		send_box(mk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_box(mk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(mk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(mk(100, 100, 100, -100, -100, -100));
		send_box(mk(300, 300, 300, -300, -300, -300));
		send_box(mk(-1, -1, -1, 0, 0, 0));
		drain_results();

		// degenerate planes: all normals zero, w = -1 culls, w = 0 sits on the plane
		mat_q = '0;
		mat_q[W_COL][W_ROW] = -ONE_Q16;
		load_matrix();
		send_box(mk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(mk(0, 0, 0, 0, 0, 0));
		drain_results();
		write_reg(REG_COL3_ROWS23, '0);
		cfg_valid <= 1'b0;
		send_box(mk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(mk(COORD_MAX, 0, COORD_MIN, COORD_MIN, 0, COORD_MAX));
		drain_results();
		write_reg(REG_SPARE_FIRST, '1);
		write_reg(REG_SPARE_LAST, '1);
		cfg_valid <= 1'b0;
		send_box(mk(5, 5, 5, 6, 6, 6));
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			span = 1 << $urandom_range(6, 20);
			fill_matrix((p == NUM_PHASES - 1) ? MAT_PROJECTIVE : mat_kind_e'(p % MAT_KIND_COUNT),
				span);
			load_matrix();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 45 == 0) begin
					gaps_on   = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
					stalls_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
				end
				if (p == 1 && n == 30)
					hold_off_asks++;
				if (p == 3 && n == 70)
					drain_results();
				send_box(random_box(span));
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== frustum_aabb_cull_core.f =====
rtl/fac_pkg.sv
rtl/fac_cfg.sv
rtl/fac_plane.sv
rtl/frustum_aabb_cull_core.sv
tb/cull_checker.sv
tb/testbench.sv
